// ----- rtl/cpp_pkg.sv -----
// cpp_pkg: shared types, constants and fixed-point helpers of the cart-pole plant step
// no dependencies; imported by every module of the block
package cpp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CART_MASS     = 3'd0,
        CFG_BAR_MASS      = 3'd1,
        CFG_BAR_LENGTH    = 3'd2,
        CFG_SAMPLE_PERIOD = 3'd3,
        CFG_START_ANGLE   = 3'd4
    } cfg_idx_t;

    // constants with 30 fraction bits
    localparam longint G_Q30           = 64'sd10533407293;
    localparam longint DT_Q30          = 64'sd5368709;
    localparam longint FOUR_THIRDS_Q30 = 64'sd1431655765;
    localparam longint PI_SRC_Q30      = 64'sd3373256577;
    localparam longint CORDIC_K_Q30    = 64'sd652032874;

    // angle constants with 16 fraction bits
    localparam int PI_Q16      = 205887;
    localparam int HALF_PI_Q16 = 102944;
    localparam int TWO_PI_Q16  = 411775;

    localparam int CORDIC_STEPS = 16;

    typedef logic signed [16:0] atan_t;
    localparam atan_t ATAN_Q16 [CORDIC_STEPS] = '{
        17'sd51472, 17'sd30386, 17'sd16055, 17'sd8150, 17'sd4091, 17'sd2047,
        17'sd1024, 17'sd512, 17'sd256, 17'sd128, 17'sd64, 17'sd32, 17'sd16,
        17'sd8, 17'sd4, 17'sd2
    };

    typedef struct packed {
        logic req;
        logic pin;
        logic halt;
        logic sing;
    } flags_t;

    typedef struct packed {
        logic signed [31:0] sin_v;
        logic signed [31:0] cos_v;
    } trig_t;

    typedef enum logic [5:0] {
        S_IDLE, S_I0, S_I1, S_I2, S_I3, S_I4, S_I5, S_WAITC,
        S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10,
        S_C11, S_C12, S_C13, S_C14, S_C15, S_C16, S_C17, S_C18, S_C19,
        S_C20, S_C21, S_PER, S_EMIT
    } seq_state_t;

    typedef enum logic [2:0] {
        CR_IDLE, CR_RED, CR_FOLD, CR_ROT, CR_FIN
    } cordic_state_t;

    typedef enum logic [1:0] {
        DV_IDLE, DV_RUN, DV_FIN
    } div_state_t;

    // rounding right shift, halves away from zero
    function automatic logic signed [64:0] rnd_shr(input logic signed [64:0] v, input int s);
        logic signed [64:0] half;
        logic signed [64:0] mag;
        if (s <= 0) begin
            return v;
        end
        half = 65'sd1 <<< (s - 1);
        if (!v[64]) begin
            return (v + half) >>> s;
        end
        mag = -v;
        return -((mag + half) >>> s);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
        if (v > 65'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -65'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return s[31:0];
    endfunction

endpackage

// ----- rtl/cpp_ifs.sv -----
// cpp_ifs: valid/ready stream interfaces for the force input and the plant result
// no dependencies
interface cpp_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_req;

    modport source (output valid, output force_req, input ready);
    modport sink   (input valid, input force_req, output ready);
endinterface

interface cpp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] cart_position;
    logic signed [31:0] bar_angle;
    logic               sample_request;
    logic               angle_pinned;
    logic               halted;
    logic               singular;

    modport source (output valid, output cart_position, output bar_angle,
                    output sample_request, output angle_pinned, output halted,
                    output singular, input ready);
    modport sink   (input valid, input cart_position, input bar_angle,
                    input sample_request, input angle_pinned, input halted,
                    input singular, output ready);
endinterface

// ----- rtl/cart_pole_plant_step.sv -----
// cart_pole_plant_step: one 5 ms euler tick per force transfer
// the cordic runs overlapped with the first products, then two divisions on the shared
// radix-2 divider and the remaining multiplier steps; no overlap of items: a new force is
// taken only when the sequencer is back in idle, after the previous result is registered
// a halted plant skips the arithmetic and answers at once; rst_n (async, active low) restores config defaults
// and the plant state, with the bar angle at the default start angle
module cart_pole_plant_step #(
    parameter int FRAC_BITS       = 16,
    parameter int PIN_LIMIT_TICKS = 1000
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cpp_in_if.sink                         in_ch,
    cpp_out_if.source                      out_ch,
    input  logic                           cfg_we,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cpp_pkg::*;

    // constants rounded from 30 fraction bits
    localparam longint HALF30 = longint'(1) << (29 - FRAC_BITS);
    localparam int     SH30   = 30 - FRAC_BITS;
    localparam logic signed [31:0] DT_V    = 32'((DT_Q30 + HALF30) >>> SH30);
    localparam logic signed [31:0] G_V     = 32'((G_Q30 + HALF30) >>> SH30);
    localparam logic signed [31:0] K43_V   = 32'((FOUR_THIRDS_Q30 + HALF30) >>> SH30);
    localparam logic signed [31:0] PIN_V   = 32'((PI_SRC_Q30 * 485 / 1000 + HALF30) >>> SH30);
    localparam logic signed [31:0] CLAMP_V = 32'((PI_SRC_Q30 * 49 / 100 + HALF30) >>> SH30);
    localparam logic [10:0]        PIN_LIM = 11'(PIN_LIMIT_TICKS);
    localparam logic [10:0]        TICK_MAX = 11'h7FF;

    seq_state_t state_reg, state_next;

    // configuration
    logic [30:0] cm_reg, cm_next;
    logic [30:0] bm_reg, bm_next;
    logic [30:0] bl_reg, bl_next;
    logic [18:0] sp_reg, sp_next;

    // plant state
    logic signed [31:0] speed_reg, speed_next;
    logic signed [31:0] pos_reg, pos_next;
    logic signed [31:0] ang_reg, ang_next;
    logic signed [31:0] rate_reg, rate_next;
    logic [10:0]        ticks_reg, ticks_next;
    logic [31:0]        period_reg, period_next;
    logic               halt_flag_reg, halt_flag_next;

    // per-tick working values
    logic signed [31:0] force_reg, force_next;
    logic signed [31:0] tmp_reg, tmp_next;
    logic signed [31:0] w_reg, w_next;
    logic signed [31:0] ml2_reg, ml2_next;
    logic signed [31:0] ml_reg, ml_next;
    logic signed [31:0] lh11_reg, lh11_next;
    logic signed [31:0] mls_reg, mls_next;
    logic signed [31:0] lh01_reg, lh01_next;
    logic signed [31:0] rh0_reg, rh0_next;
    logic signed [31:0] rh1_reg, rh1_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] det_reg, det_next;
    logic signed [31:0] ddx_reg, ddx_next;
    logic signed [31:0] ddth_reg, ddth_next;
    flags_t             flags_reg, flags_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_pos_reg, out_pos_next;
    logic signed [31:0] out_ang_reg, out_ang_next;
    flags_t             out_flags_reg, out_flags_next;

    // shared units
    logic               mul_en;
    logic signed [31:0] mul_a, mul_b, mul_q;
    logic signed [63:0] mul_p;
    logic               cordic_start, cordic_busy;
    trig_t              trig;
    logic               div_start, div_busy;
    logic signed [31:0] div_q;

    logic               accept;
    logic signed [31:0] lh00;
    logic signed [31:0] cm_s, bm_s, bl_s;
    logic [32:0]        ang_abs;
    logic               pinned;
    logic signed [31:0] ang_sum;
    logic [32:0]        per_sum;
    logic [31:0]        per_acc;

    cpp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_p),
        .q    (mul_q)
    );

    cpp_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (ang_reg),
        .busy   (cordic_busy),
        .result (trig)
    );

    cpp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (acc_reg),
        .den   (det_reg),
        .busy  (div_busy),
        .quo   (div_q)
    );

    assign accept = in_ch.valid && in_ch.ready;
    assign cm_s   = {1'b0, cm_reg};
    assign bm_s   = {1'b0, bm_reg};
    assign bl_s   = {1'b0, bl_reg};
    assign lh00   = add_sat(cm_s, bm_s);

    always_comb
    begin
        ang_abs = ang_reg[31] ? 33'(-{ang_reg[31], ang_reg}) : {1'b0, ang_reg};
        pinned  = !(ang_abs < {1'b0, PIN_V});
        ang_sum = add_sat(ang_reg, mul_q);
        // period accumulator saturates at all ones
        per_sum = {1'b0, period_reg} + {1'b0, DT_V};
        per_acc = per_sum[32] ? 32'hFFFF_FFFF : per_sum[31:0];
    end

    // sequencer: most steps capture the previous product and issue the next
    always_comb
    begin
        state_next     = state_reg;
        cm_next        = cm_reg;
        bm_next        = bm_reg;
        bl_next        = bl_reg;
        sp_next        = sp_reg;
        speed_next     = speed_reg;
        pos_next       = pos_reg;
        ang_next       = ang_reg;
        rate_next      = rate_reg;
        ticks_next     = ticks_reg;
        period_next    = period_reg;
        halt_flag_next = halt_flag_reg;
        force_next     = force_reg;
        tmp_next       = tmp_reg;
        w_next         = w_reg;
        ml2_next       = ml2_reg;
        ml_next        = ml_reg;
        lh11_next      = lh11_reg;
        mls_next       = mls_reg;
        lh01_next      = lh01_reg;
        rh0_next       = rh0_reg;
        rh1_next       = rh1_reg;
        acc_next       = acc_reg;
        det_next       = det_reg;
        ddx_next       = ddx_reg;
        ddth_next      = ddth_reg;
        flags_next     = flags_reg;
        out_valid_next = out_valid_reg;
        out_pos_next   = out_pos_reg;
        out_ang_next   = out_ang_reg;
        out_flags_next = out_flags_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        cordic_start   = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (halt_flag_reg)
                    begin
                        flags_next = '{req: 1'b0, pin: 1'b1, halt: 1'b1, sing: 1'b0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        force_next   = in_ch.force_req;
                        cordic_start = 1'b1;
                        state_next   = S_I0;
                    end
                end
            end
            S_I0:
            begin
                mul_en = 1'b1; mul_a = bl_s; mul_b = bl_s;
                state_next = S_I1;
            end
            S_I1:
            begin
                tmp_next = mul_q;
                mul_en = 1'b1; mul_a = rate_reg; mul_b = rate_reg;
                state_next = S_I2;
            end
            S_I2:
            begin
                w_next = mul_q;
                mul_en = 1'b1; mul_a = bm_s; mul_b = tmp_reg;
                state_next = S_I3;
            end
            S_I3:
            begin
                ml2_next = mul_q;
                mul_en = 1'b1; mul_a = bm_s; mul_b = bl_s;
                state_next = S_I4;
            end
            S_I4:
            begin
                ml_next = mul_q;
                mul_en = 1'b1; mul_a = K43_V; mul_b = ml2_reg;
                state_next = S_I5;
            end
            S_I5:
            begin
                lh11_next  = add_sat(mul_q, ml2_reg);
                state_next = S_WAITC;
            end
            S_WAITC:
            begin
                if (!cordic_busy)
                begin
                    mul_en = 1'b1; mul_a = ml_reg; mul_b = trig.sin_v;
                    state_next = S_C1;
                end
            end
            S_C1:
            begin
                mls_next = mul_q;
                mul_en = 1'b1; mul_a = ml_reg; mul_b = trig.cos_v;
                state_next = S_C2;
            end
            S_C2:
            begin
                lh01_next = mul_q;
                mul_en = 1'b1; mul_a = mls_reg; mul_b = w_reg;
                state_next = S_C3;
            end
            S_C3:
            begin
                rh0_next = add_sat(force_reg, mul_q);
                mul_en = 1'b1; mul_a = mls_reg; mul_b = G_V;
                state_next = S_C4;
            end
            S_C4:
            begin
                rh1_next = mul_q;
                mul_en = 1'b1; mul_a = lh00; mul_b = lh11_reg;
                state_next = S_C5;
            end
            S_C5:
            begin
                acc_next = mul_p;
                mul_en = 1'b1; mul_a = lh01_reg; mul_b = lh01_reg;
                state_next = S_C6;
            end
            S_C6:
            begin
                acc_next   = acc_reg - mul_p;
                state_next = S_C7;
            end
            S_C7:
            begin
                // determinant of the mass matrix
                det_next = sat32(rnd_shr({acc_reg[63], acc_reg}, FRAC_BITS));
                mul_en = 1'b1; mul_a = lh11_reg; mul_b = rh0_reg;
                state_next = S_C8;
            end
            S_C8:
            begin
                if (det_reg == '0)
                begin
                    // singular matrix: plant state untouched
                    flags_next = '{req: 1'b0, pin: 1'b0, halt: 1'b0, sing: 1'b1};
                    state_next = S_EMIT;
                end
                else
                begin
                    acc_next = mul_p;
                    mul_en = 1'b1; mul_a = lh01_reg; mul_b = rh1_reg;
                    state_next = S_C9;
                end
            end
            S_C9:
            begin
                acc_next = acc_reg - mul_p;
                mul_en = 1'b1; mul_a = lh00; mul_b = rh1_reg;
                state_next = S_C10;
            end
            S_C10:
            begin
                // divider takes the cart numerator, acc moves on to the bar numerator
                div_start = 1'b1;
                acc_next  = mul_p;
                mul_en = 1'b1; mul_a = lh01_reg; mul_b = rh0_reg;
                state_next = S_C11;
            end
            S_C11:
            begin
                acc_next   = acc_reg - mul_p;
                state_next = S_C12;
            end
            S_C12:
            begin
                if (!div_busy)
                begin
                    ddx_next   = div_q;
                    state_next = S_C13;
                end
            end
            S_C13:
            begin
                div_start = 1'b1;
                mul_en = 1'b1; mul_a = DT_V; mul_b = ddx_reg;
                state_next = S_C14;
            end
            S_C14:
            begin
                speed_next = add_sat(speed_reg, mul_q);
                state_next = S_C15;
            end
            S_C15:
            begin
                mul_en = 1'b1; mul_a = speed_reg; mul_b = DT_V;
                state_next = S_C16;
            end
            S_C16:
            begin
                pos_next   = add_sat(pos_reg, mul_q);
                state_next = S_C17;
            end
            S_C17:
            begin
                if (!div_busy)
                begin
                    ddth_next  = div_q;
                    state_next = S_C18;
                end
            end
            S_C18:
            begin
                mul_en = 1'b1; mul_a = DT_V; mul_b = ddth_reg;
                state_next = S_C19;
            end
            S_C19:
            begin
                if (!pinned)
                begin
                    rate_next  = add_sat(rate_reg, mul_q);
                    state_next = S_C20;
                end
                else
                begin
                    // bar held at the joint stop
                    rate_next  = '0;
                    ang_next   = (ang_reg > 0) ? CLAMP_V : -CLAMP_V;
                    if (ticks_reg != TICK_MAX)
                    begin
                        ticks_next = ticks_reg + 1'b1;
                    end
                    if (ticks_reg >= PIN_LIM)
                    begin
                        halt_flag_next = 1'b1;
                        flags_next = '{req: 1'b0, pin: 1'b1, halt: 1'b1, sing: 1'b0};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        flags_next.pin = 1'b1;
                        state_next     = S_PER;
                    end
                end
            end
            S_C20:
            begin
                mul_en = 1'b1; mul_a = rate_reg; mul_b = DT_V;
                state_next = S_C21;
            end
            S_C21:
            begin
                if (ang_sum > CLAMP_V)
                begin
                    ang_next = CLAMP_V;
                end
                else if (ang_sum < -CLAMP_V)
                begin
                    ang_next = -CLAMP_V;
                end
                else
                begin
                    ang_next = ang_sum;
                end
                ticks_next     = '0;
                flags_next.pin = 1'b0;
                state_next     = S_PER;
            end
            S_PER:
            begin
                flags_next.halt = 1'b0;
                flags_next.sing = 1'b0;
                if (per_acc >= 32'(sp_reg))
                begin
                    flags_next.req = 1'b1;
                    period_next    = per_acc - 32'(sp_reg);
                end
                else
                begin
                    flags_next.req = 1'b0;
                    period_next    = per_acc;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // result register free or draining this cycle
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_reg;
                    out_ang_next   = ang_reg;
                    out_flags_next = flags_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // configuration writes must arrive only while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_CART_MASS:     cm_next = cfg_data;
                CFG_BAR_MASS:      bm_next = cfg_data;
                CFG_BAR_LENGTH:    bl_next = cfg_data;
                CFG_SAMPLE_PERIOD: sp_next = cfg_data[18:0];
                CFG_START_ANGLE:   ang_next = {{14{cfg_data[17]}}, cfg_data[17:0]};
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cm_reg        <= 31'd65536;
            bm_reg        <= 31'd65536;
            bl_reg        <= 31'd655360;
            sp_reg        <= 19'd65536;
            speed_reg     <= '0;
            pos_reg       <= '0;
            ang_reg       <= 32'sd6554;
            rate_reg      <= '0;
            ticks_reg     <= '0;
            period_reg    <= '0;
            halt_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cm_reg        <= cm_next;
            bm_reg        <= bm_next;
            bl_reg        <= bl_next;
            sp_reg        <= sp_next;
            speed_reg     <= speed_next;
            pos_reg       <= pos_next;
            ang_reg       <= ang_next;
            rate_reg      <= rate_next;
            ticks_reg     <= ticks_next;
            period_reg    <= period_next;
            halt_flag_reg <= halt_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        force_reg     <= force_next;
        tmp_reg       <= tmp_next;
        w_reg         <= w_next;
        ml2_reg       <= ml2_next;
        ml_reg        <= ml_next;
        lh11_reg      <= lh11_next;
        mls_reg       <= mls_next;
        lh01_reg      <= lh01_next;
        rh0_reg       <= rh0_next;
        rh1_reg       <= rh1_next;
        acc_reg       <= acc_next;
        det_reg       <= det_next;
        ddx_reg       <= ddx_next;
        ddth_reg      <= ddth_next;
        flags_reg     <= flags_next;
        out_pos_reg   <= out_pos_next;
        out_ang_reg   <= out_ang_next;
        out_flags_reg <= out_flags_next;
    end

    // ports
    assign in_ch.ready           = (state_reg == S_IDLE);
    assign out_ch.valid          = out_valid_reg;
    assign out_ch.cart_position  = out_pos_reg;
    assign out_ch.bar_angle      = out_ang_reg;
    assign out_ch.sample_request = out_flags_reg.req;
    assign out_ch.angle_pinned   = out_flags_reg.pin;
    assign out_ch.halted         = out_flags_reg.halt;
    assign out_ch.singular       = out_flags_reg.sing;

    // a transfer in always starts a tick
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted tick did not start");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_flag_reg |=> halt_flag_reg)
        else $error("halt flag cleared");

    // a halted result is pinned, never singular, never a sample request
    a_halt_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.halted |->
            out_ch.angle_pinned && !out_ch.singular && !out_ch.sample_request)
        else $error("inconsistent halted result");

    // the divider is never restarted while busy
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");
endmodule

// ----- rtl/cpp_mul.sv -----
// cpp_mul: shared 32x32 signed multiplier with registered product
// depends on cpp_pkg for rounding and saturation
module cpp_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] prod,
    output logic signed [31:0] q
);
    import cpp_pkg::*;

    logic signed [63:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;
    // rounded, saturated fixed-point product
    assign q    = sat32(rnd_shr({prod_reg[63], prod_reg}, FRAC_BITS));
endmodule

// ----- rtl/cpp_cordic.sv -----
// cpp_cordic: iterative angle reduction and 16-step rotation cordic for sine and cosine
// depends on cpp_pkg for the arctangent table and angle constants
module cpp_cordic #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               busy,
    output cpp_pkg::trig_t     result
);
    import cpp_pkg::*;

    localparam int SHL   = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam int ZW    = 33 + SHL;
    localparam int RED_N = ZW - 18;
    localparam int KW    = $clog2(RED_N);
    localparam int RW    = ZW + 20;

    cordic_state_t      state_reg, state_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [3:0]         i_reg, i_next;
    logic [ZW-1:0]      zmag_reg, zmag_next;
    logic               zneg_reg, zneg_next;
    logic               neg_reg, neg_next;
    logic signed [20:0] z_reg, z_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    trig_t              res_reg, res_next;

    logic signed [64:0] a65;
    logic signed [64:0] zfull;
    logic signed [ZW-1:0] z0;
    logic [RW-1:0]      sub_v;
    logic signed [20:0] zr;
    logic signed [33:0] xs, ys, xf, yf;

    always_comb
    begin
        a65   = {{33{angle[31]}}, angle};
        zfull = (FRAC_BITS >= 16) ? rnd_shr(a65, FRAC_BITS - 16) : (a65 <<< SHL);
        z0    = zfull[ZW-1:0];
        sub_v = RW'(TWO_PI_Q16) << k_reg;
        zr    = zneg_reg ? -21'(zmag_reg[19:0]) : 21'(zmag_reg[19:0]);
        xs    = x_reg >>> i_reg;
        ys    = y_reg >>> i_reg;
        xf    = neg_reg ? -x_reg : x_reg;
        yf    = neg_reg ? -y_reg : y_reg;

        state_next = state_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        zmag_next  = zmag_reg;
        zneg_next  = zneg_reg;
        neg_next   = neg_reg;
        z_next     = z_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        res_next   = res_reg;

        unique case (state_reg)
            CR_IDLE:
            begin
                if (start)
                begin
                    zneg_next  = z0[ZW-1];
                    zmag_next  = z0[ZW-1] ? ZW'(-z0) : ZW'(z0);
                    k_next     = KW'(RED_N - 1);
                    state_next = CR_RED;
                end
            end
            CR_RED:
            begin
                // one conditional subtract of 2*pi*2^k per cycle
                if ({20'd0, zmag_reg} >= sub_v)
                begin
                    zmag_next = zmag_reg - sub_v[ZW-1:0];
                end
                if (k_reg == '0)
                begin
                    state_next = CR_FOLD;
                end
                else
                begin
                    k_next = k_reg - 1'b1;
                end
            end
            CR_FOLD:
            begin
                z_next   = zr;
                neg_next = 1'b0;
                if (zr > 21'sd205887)
                begin
                    z_next = zr - 21'(TWO_PI_Q16);
                end
                else if (zr < -21'sd205887)
                begin
                    z_next = zr + 21'(TWO_PI_Q16);
                end
                if (z_next > 21'(HALF_PI_Q16))
                begin
                    z_next   = z_next - 21'(PI_Q16);
                    neg_next = 1'b1;
                end
                else if (z_next < -21'(HALF_PI_Q16))
                begin
                    z_next   = z_next + 21'(PI_Q16);
                    neg_next = 1'b1;
                end
                x_next     = 34'(CORDIC_K_Q30);
                y_next     = '0;
                i_next     = '0;
                state_next = CR_ROT;
            end
            CR_ROT:
            begin
                if (!z_reg[20])
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - 21'(ATAN_Q16[i_reg]);
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + 21'(ATAN_Q16[i_reg]);
                end
                i_next = i_reg + 1'b1;
                if (i_reg == 4'(CORDIC_STEPS - 1))
                begin
                    state_next = CR_FIN;
                end
            end
            CR_FIN:
            begin
                res_next.cos_v = sat32(rnd_shr({{31{xf[33]}}, xf}, 30 - FRAC_BITS));
                res_next.sin_v = sat32(rnd_shr({{31{yf[33]}}, yf}, 30 - FRAC_BITS));
                state_next     = CR_IDLE;
            end
            default:
            begin
                state_next = CR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CR_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        i_reg    <= i_next;
        zmag_reg <= zmag_next;
        zneg_reg <= zneg_next;
        neg_reg  <= neg_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        res_reg  <= res_next;
    end

    assign busy   = (state_reg != CR_IDLE);
    assign result = res_reg;
endmodule

// ----- rtl/cpp_div.sv -----
// cpp_div: radix-2 restoring divider, 64-bit signed by 32-bit signed, truncating, saturating
// depends on cpp_pkg for the state type and saturation
module cpp_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quo
);
    import cpp_pkg::*;

    div_state_t         state_reg, state_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        lo_reg, lo_next;
    logic [31:0]        dmag_reg, dmag_next;
    logic               sign_reg, sign_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] quo_reg, quo_next;

    logic [63:0]        nmag;
    logic [31:0]        dmag;
    logic [32:0]        trial;
    logic signed [32:0] qs;

    always_comb
    begin
        nmag  = num[63] ? 64'(-num) : 64'(num);
        dmag  = den[31] ? 32'(-den) : 32'(den);
        trial = {rem_reg, lo_reg[31]};
        qs    = sign_reg ? -33'({1'b0, lo_reg}) : 33'({1'b0, lo_reg});

        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        dmag_next  = dmag_reg;
        sign_next  = sign_reg;
        ovf_next   = ovf_reg;
        quo_next   = quo_reg;

        unique case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    rem_next   = nmag[63:32];
                    lo_next    = nmag[31:0];
                    dmag_next  = dmag;
                    sign_next  = num[63] ^ den[31];
                    // quotient of 2^32 or more ends the run early and saturates
                    ovf_next   = (nmag[63:32] >= dmag);
                    cnt_next   = '0;
                    state_next = DV_RUN;
                end
            end
            DV_RUN:
            begin
                if (trial >= {1'b0, dmag_reg})
                begin
                    rem_next = 32'(trial - {1'b0, dmag_reg});
                    lo_next  = {lo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    lo_next  = {lo_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31 || ovf_reg)
                begin
                    state_next = DV_FIN;
                end
            end
            DV_FIN:
            begin
                if (ovf_reg)
                begin
                    quo_next = sign_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
                else
                begin
                    quo_next = sat32(65'(qs));
                end
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        dmag_reg <= dmag_next;
        sign_reg <= sign_next;
        ovf_reg  <= ovf_next;
        quo_reg  <= quo_next;
    end

    assign busy = (state_reg != DV_IDLE);
    assign quo  = quo_reg;
endmodule

// ----- tb/sv/cart_pole_plant_step_checker.sv -----
// cart_pole_plant_step_checker: watches the force and result channels and the config port,
// predicts each tick of the plant and compares results; depends on cpp_pkg and cpp_ifs
module cart_pole_plant_step_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    cpp_in_if                              in_ch,
    cpp_out_if                             out_ch,
    input  logic                           cfg_we,
    input  logic [cpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cpp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cpp_pkg::*;

    localparam int     FRAC      = 16;
    localparam int     PIN_TICKS = 1000;
    localparam longint ATAN_TAB [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                         256, 128, 64, 32, 16, 8, 4, 2};

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] ang;
        logic               req;
        logic               pin;
        logic               halt;
        logic               sing;
    } tick_result_t;

    tick_result_t tick_q [$];

    longint m_cart, m_bar, len_bar, period, angle_init;
    longint speed, pos, angle, rate;
    int     pin_count;
    longint accum;
    bit     halt_seen;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shift(longint v, int s);
        longint half;
        if (s <= 0) return v;
        half = 64'sd1 <<< (s - 1);
        if (v >= 0) return (v + half) >>> s;
        return -((-v + half) >>> s);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return clamp32(round_shift(a * b, FRAC));
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return clamp32(a + b);
    endfunction

    function automatic longint to_q16(longint v);
        return round_shift(v, 30 - FRAC);
    endfunction

    // 16-step rotation cordic on an angle folded into +-pi/2
    function automatic void trig_of(input longint a, output longint s, output longint c);
        longint z, x, y, nx;
        bit flip;
        flip = 0;
        z = a % TWO_PI_Q16;
        if (z > PI_Q16) z -= TWO_PI_Q16;
        if (z < -PI_Q16) z += TWO_PI_Q16;
        if (z > HALF_PI_Q16) begin
            z -= PI_Q16;
            flip = 1;
        end
        else if (z < -HALF_PI_Q16) begin
            z += PI_Q16;
            flip = 1;
        end
        x = CORDIC_K_Q30;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= ATAN_TAB[i];
            end
            else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += ATAN_TAB[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = to_q16(x);
        s = to_q16(y);
    endfunction

    function automatic tick_result_t hold_result(bit req, bit pin, bit halt, bit sing);
        tick_result_t r;
        r.pos  = pos[31:0];
        r.ang  = angle[31:0];
        r.req  = req;
        r.pin  = pin;
        r.halt = halt;
        r.sing = sing;
        return r;
    endfunction

    // one euler tick of the plant
    function automatic tick_result_t plant_tick(logic signed [31:0] f_in);
        longint f, s, c, ml, ml2, a00, a01, a11, b0, b1, mls, det, ddx, ddth, mag;
        longint dt, lim_pin, lim_clamp, acc;
        bit req, pin;
        req = 0;
        pin = 0;
        dt        = to_q16(DT_Q30);
        lim_pin   = to_q16(PI_SRC_Q30 * 485 / 1000);
        lim_clamp = to_q16(PI_SRC_Q30 * 49 / 100);
        if (halt_seen) return hold_result(0, 1, 1, 0);
        f = f_in;
        trig_of(angle, s, c);
        ml  = fx_mul(m_bar, len_bar);
        ml2 = fx_mul(m_bar, fx_mul(len_bar, len_bar));
        a00 = fx_add(m_cart, m_bar);
        a01 = fx_mul(ml, c);
        a11 = fx_add(fx_mul(to_q16(FOUR_THIRDS_Q30), ml2), ml2);
        mls = fx_mul(ml, s);
        b0  = fx_add(f, fx_mul(mls, fx_mul(rate, rate)));
        b1  = fx_mul(mls, to_q16(G_Q30));
        det = clamp32(round_shift(a00 * a11 - a01 * a01, FRAC));
        if (det == 0) return hold_result(0, 0, 0, 1);
        ddx  = clamp32((a11 * b0 - a01 * b1) / det);
        ddth = clamp32((a00 * b1 - a01 * b0) / det);
        speed = fx_add(speed, fx_mul(dt, ddx));
        pos   = fx_add(pos, fx_mul(speed, dt));
        mag = angle < 0 ? -angle : angle;
        if (mag < lim_pin) begin
            rate  = fx_add(rate, fx_mul(dt, ddth));
            angle = fx_add(angle, fx_mul(rate, dt));
            if (angle > lim_clamp) angle = lim_clamp;
            else if (angle < -lim_clamp) angle = -lim_clamp;
            pin_count = 0;
        end
        else begin
            pin  = 1;
            rate = 0;
            angle = angle > 0 ? lim_clamp : -lim_clamp;
            if (pin_count >= PIN_TICKS) begin
                if (pin_count < 2047) pin_count++;
                halt_seen = 1;
                return hold_result(0, 1, 1, 0);
            end
            if (pin_count < 2047) pin_count++;
        end
        acc = accum + dt;
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        if (acc >= period) begin
            req = 1;
            acc -= period;
        end
        accum = acc;
        return hold_result(req, pin, 0, 0);
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        tick_result_t want;
        if (!rst_n) begin
            m_cart = 65536;
            m_bar = 65536;
            len_bar = 655360;
            period = 65536;
            angle_init = 6554;
            speed = 0;
            pos = 0;
            angle = angle_init;
            rate = 0;
            pin_count = 0;
            accum = 0;
            halt_seen = 0;
            tick_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_CART_MASS:     m_cart = cfg_data;
                    CFG_BAR_MASS:      m_bar = cfg_data;
                    CFG_BAR_LENGTH:    len_bar = cfg_data;
                    CFG_SAMPLE_PERIOD: period = cfg_data[18:0];
                    CFG_START_ANGLE:
                    begin
                        angle_init = longint'(signed'(cfg_data[17:0]));
                        angle = angle_init;
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (tick_q.size() == 0) begin
                    // result transfer with no tick outstanding
                    report("outstanding ticks", 0, 1);
                end
                else begin
                    want = tick_q.pop_front();
                    if (out_ch.cart_position !== want.pos)
                        report("cart_position", out_ch.cart_position, want.pos);
                    if (out_ch.bar_angle !== want.ang)
                        report("bar_angle", out_ch.bar_angle, want.ang);
                    if (out_ch.sample_request !== want.req)
                        report("sample_request", out_ch.sample_request, want.req);
                    if (out_ch.angle_pinned !== want.pin)
                        report("angle_pinned", out_ch.angle_pinned, want.pin);
                    if (out_ch.halted !== want.halt)
                        report("halted", out_ch.halted, want.halt);
                    if (out_ch.singular !== want.sing)
                        report("singular", out_ch.singular, want.sing);
                end
            end
            if (in_ch.valid && in_ch.ready)
                tick_q.push_back(plant_tick(in_ch.force_req));
            pending = tick_q.size();
        end
    end

endmodule

// ----- tb/sv/cart_pole_plant_step_test.sv -----
// cart_pole_plant_step_test: stimulus and verdict for the cart-pole plant step
// depends on cpp_pkg, cpp_ifs, the block and cart_pole_plant_step_checker
module cart_pole_plant_step_test;
    timeunit 1ns;
    timeprecision 1ps;
    import cpp_pkg::*;

    // index with no register behind it, the write must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;
    localparam int SETTLE_CYCLES = 300;
    localparam int MAX_START     = 102943;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int fail_count;
    int pending;

    // percent of cycles each side idles
    int send_idle;
    int recv_idle;

    cpp_in_if  in_ch ();
    cpp_out_if out_ch ();

    cart_pole_plant_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cart_pole_plant_step_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver stalls at random, one decision per cycle
    always @(negedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // 0: sender idles 30, receiver 70; 1: the other way round; 2: no idling
    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle = 30;
                recv_idle = 70;
            end
            1:
            begin
                send_idle = 70;
                recv_idle = 30;
            end
            default:
            begin
                send_idle = 0;
                recv_idle = 0;
            end
        endcase
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_force(logic signed [31:0] f);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.force_req = f;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
    endtask

    // wait for every outstanding tick result, then give the block time to go quiet
    task automatic settle();
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] angle_word(int a);
        return CFG_DATA_W'(a) & 31'h3FFFF;
    endfunction

    // mostly modest forces so the plant moves, sometimes any 32-bit value
    function automatic logic signed [31:0] random_force();
        if ($urandom_range(3) == 0) return $urandom;
        return $signed($urandom_range(2 * 655360)) - 655360;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_mass();
        if ($urandom_range(4) == 0) return CFG_DATA_W'($urandom_range(31'h7FFF_FFFF, 1));
        return CFG_DATA_W'($urandom_range(20 * 65536, 1));
    endfunction

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.force_req = '0;
        set_idling(2);
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: force extremes with the reset configuration
        send_force(32'sd0);
        send_force(32'sh7FFF_FFFF);
        send_force(32'sh8000_0000);
        send_force(32'sd1);
        send_force(-32'sd1);
        send_force(32'sd65536);
        send_force(-32'sd65536);
        send_force(32'shAAAA_5555);
        settle();

        // zero masses give a zero determinant: state held, singular set
        write_reg(CFG_CART_MASS, '0);
        write_reg(CFG_BAR_MASS, '0);
        send_force(32'sh7FFF_FFFF);
        send_force(32'sh5555_AAAA);
        settle();
        // zero bar length also makes the matrix singular
        write_reg(CFG_CART_MASS, 31'd65536);
        write_reg(CFG_BAR_MASS, 31'd65536);
        write_reg(CFG_BAR_LENGTH, '0);
        send_force(32'sh8000_0000);
        send_force(32'sd65536);
        settle();

        // largest registers, period zero requests every tick, bar pinned negative
        write_reg(CFG_CART_MASS, 31'h7FFF_FFFF);
        write_reg(CFG_BAR_MASS, 31'h7FFF_FFFF);
        write_reg(CFG_BAR_LENGTH, 31'h7FFF_FFFF);
        write_reg(CFG_SAMPLE_PERIOD, '0);
        write_reg(CFG_START_ANGLE, angle_word(-MAX_START));
        write_reg(CFG_UNUSED_IDX, 31'h7FFF_FFFF);
        send_force(32'sh7FFF_FFFF);
        send_force(32'sh8000_0000);
        send_force(32'sd0);
        settle();

        // smallest masses and length, longest period, upright bar
        write_reg(CFG_CART_MASS, 31'd1);
        write_reg(CFG_BAR_MASS, 31'd1);
        write_reg(CFG_BAR_LENGTH, 31'd1);
        write_reg(CFG_SAMPLE_PERIOD, 31'd327680);
        write_reg(CFG_START_ANGLE, angle_word(0));
        send_force(32'sd0);
        send_force(32'sh7FFF_FFFF);
        send_force(-32'sd1);
        settle();

        // random phases with random settings, idling mode changes every two phases
        for (int ph = 0; ph < 6; ph++) begin
            set_idling(ph / 2);
            write_reg(CFG_CART_MASS, random_mass());
            write_reg(CFG_BAR_MASS, random_mass());
            write_reg(CFG_BAR_LENGTH, random_mass());
            write_reg(CFG_SAMPLE_PERIOD, CFG_DATA_W'($urandom_range(327680, 655)));
            write_reg(CFG_START_ANGLE, angle_word($signed($urandom_range(2 * MAX_START))
                                                  - MAX_START));
            for (int i = 0; i < 65; i++) send_force(random_force());
            settle();
        end

        // bar starts past the pin limit and stays pinned until the plant halts,
        // then a few ticks after the halt which must change nothing
        write_reg(CFG_CART_MASS, 31'd65536);
        write_reg(CFG_BAR_MASS, 31'd65536);
        write_reg(CFG_BAR_LENGTH, 31'd655360);
        write_reg(CFG_SAMPLE_PERIOD, 31'd655);
        write_reg(CFG_START_ANGLE, angle_word(MAX_START));
        for (int i = 0; i < 1040; i++) begin
            if (i % 350 == 0) set_idling(i / 350);
            send_force(random_force());
        end
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end
        else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #100_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
